// File: design/hgba_pkg.sv
// Shared types and constants of the hash group-by aggregator.
// Holds table geometry, opcodes, status codes and the stored entry layout.
// No dependencies.
package hgba_pkg;

  // Table geometry. The home slot is the low key bits, so the size is a power of two.
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W        = 10;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Status codes of a result transaction.
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  // One table entry as it is kept in memory.
  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [31:0] count;
    logic [63:0] sum;
    logic [31:0] min_v;
    logic [31:0] max_v;
  } entry_t;

  // Outcome of comparing one probed entry against the item's key.
  typedef struct packed {
    logic hit;
    logic empty;
  } probe_t;

endpackage

// File: design/hgba_merge.sv
// Probe evaluation and entry update for one accumulate step.
// Compares the probed entry with the key and builds the entry to write back.
// Depends on hgba_pkg.
module hgba_merge import hgba_pkg::*; (
  input  entry_t      cur,
  input  logic [31:0] agg_key,
  input  logic [31:0] sum_value,
  input  logic [31:0] min_value,
  input  logic [31:0] max_value,
  output probe_t      outcome,
  output entry_t      merged
);

  // Classify the probed slot.
  assign outcome.hit   = cur.used && (cur.key == agg_key);
  assign outcome.empty = !cur.used;

  // Either fold the element into the group or start a new group.
  always_comb begin
    if (outcome.hit) begin
      merged.used  = 1'b1;
      merged.key   = cur.key;
      merged.count = cur.count + 32'd1;
      merged.sum   = cur.sum + {32'd0, sum_value};
      merged.min_v = (min_value < cur.min_v) ? min_value : cur.min_v;
      merged.max_v = (max_value > cur.max_v) ? max_value : cur.max_v;
    end else begin
      merged.used  = 1'b1;
      merged.key   = agg_key;
      merged.count = 32'd1;
      merged.sum   = {32'd0, sum_value};
      merged.min_v = min_value;
      merged.max_v = max_value;
    end
  end

endmodule

// File: design/hash_group_by_aggregator.sv
// Top level of the hash group-by aggregator.
// Holds the entry memory, the probe sequencer and the result register.
// Depends on hgba_pkg and hgba_merge.
//
// Usage: the input channel (in_valid/in_ready) carries one transaction per
// item: accumulate, read entry or clear table. The output channel
// (out_valid/out_ready) returns exactly one result transaction per item.
// Every table slot lives in one memory with a registered read; an accumulate
// reads its home slot (low key bits) when accepted and checks it in the next
// cycle. A hit or an empty slot is written back and the result loaded once
// the output register is free; an occupied slot with a different key moves
// the probe on to the slot after it, wrapping at the end, and a table with
// every slot probed and none matching or empty is reported full. A clear
// sweeps the memory one slot per cycle, holding at the last slot until the
// output register is free. Reset runs the same sweep over all TABLE_ENTRIES
// slots with in_ready low and no result. A result waits in the output register
// while the receiver stalls; the next item is still accepted, and only its own
// completion waits for the register to free up.
module hash_group_by_aggregator import hgba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [31:0]       agg_key,
  input  logic [31:0]       sum_value,
  input  logic [31:0]       min_value,
  input  logic [31:0]       max_value,
  input  logic [9:0]        entry_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [SLOT_W-1:0] slot,
  output logic              entry_used,
  output logic [31:0]       entry_key,
  output logic [31:0]       entry_count,
  output logic [63:0]       entry_sum,
  output logic [31:0]       entry_min,
  output logic [31:0]       entry_max
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0]       state;
  logic [1:0]       op_q;
  logic [31:0]      key_q;
  logic [31:0]      sval_q;
  logic [31:0]      mnv_q;
  logic [31:0]      mxv_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] probes;
  logic             in_range;
  logic [IDX_W-1:0] clr_cnt;
  logic             clear_report;

  entry_t           ent_mem [TABLE_ENTRIES];
  entry_t           rd_data;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  probe_t           outcome;
  entry_t           merged;
  entry_t           shown;

  logic             accept;
  logic             out_free;
  logic             is_accum;
  logic             last_probe;
  logic             advance;
  logic             finish;
  logic             clear_done;
  logic [IDX_W-1:0] next_idx;
  logic [IDX_W-1:0] start_idx;

  // Probe evaluation on the entry held in the memory's read register.
  hgba_merge u_merge (
    .cur       (rd_data),
    .agg_key   (key_q),
    .sum_value (sval_q),
    .min_value (mnv_q),
    .max_value (mxv_q),
    .outcome   (outcome),
    .merged    (merged)
  );

  // Handshake and sequencing conditions.
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign is_accum   = (op_q == OP_ACCUM);
  assign last_probe = (probes == LAST_IDX);
  assign next_idx   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign advance    = (state == S_PROBE) && is_accum && !outcome.hit && !outcome.empty
                      && !last_probe;
  assign finish     = (state == S_PROBE) && out_free
                      && (!is_accum || outcome.hit || outcome.empty || last_probe);
  assign clear_done = (state == S_CLEAR) && (clr_cnt == LAST_IDX)
                      && (!clear_report || out_free);
  assign start_idx  = (op == OP_ACCUM) ? IDX_W'(agg_key) : IDX_W'(entry_index);

  // Memory port control.
  always_comb begin
    mem_re    = (accept && (op != OP_CLEAR)) || advance;
    mem_raddr = accept ? start_idx : next_idx;
    mem_we    = (state == S_CLEAR)
                || (finish && is_accum && (outcome.hit || outcome.empty));
    mem_waddr = (state == S_CLEAR) ? clr_cnt : idx_q;
    mem_wdata = (state == S_CLEAR) ? '0 : merged;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ent_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= ent_mem[mem_raddr];
    end
  end

  // Entry shown in a result: the updated group, or the slot read if it holds one.
  always_comb begin
    if (is_accum) begin
      shown = merged;
    end else if (in_range && rd_data.used) begin
      shown = rd_data;
    end else begin
      shown = '0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      clear_report <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= op;
            key_q    <= agg_key;
            sval_q   <= sum_value;
            mnv_q    <= min_value;
            mxv_q    <= max_value;
            idx_q    <= start_idx;
            probes   <= '0;
            in_range <= (op == OP_ACCUM) || (32'(entry_index) < 32'(TABLE_ENTRIES));
            if (op == OP_CLEAR) begin
              state        <= S_CLEAR;
              clr_cnt      <= '0;
              clear_report <= 1'b1;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (advance) begin
            idx_q  <= next_idx;
            probes <= probes + 1'b1;
          end else if (finish) begin
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          if (clear_done) begin
            state <= S_IDLE;
          end else if (clr_cnt != LAST_IDX) begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish || (clear_done && clear_report)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (!is_accum) begin
        status <= ST_READ;
      end else if (outcome.hit) begin
        status <= ST_HIT;
      end else if (outcome.empty) begin
        status <= ST_NEW;
      end else begin
        status <= ST_FULL;
      end
      if (is_accum && !outcome.hit && !outcome.empty) begin
        slot        <= '0;
        entry_used  <= 1'b0;
        entry_key   <= '0;
        entry_count <= '0;
        entry_sum   <= '0;
        entry_min   <= '0;
        entry_max   <= '0;
      end else begin
        slot        <= SLOT_W'(idx_q);
        entry_used  <= shown.used;
        entry_key   <= shown.key;
        entry_count <= shown.count;
        entry_sum   <= shown.sum;
        entry_min   <= shown.min_v;
        entry_max   <= shown.max_v;
      end
    end else if (clear_done && clear_report) begin
      status      <= ST_CLEARED;
      slot        <= '0;
      entry_used  <= 1'b0;
      entry_key   <= '0;
      entry_count <= '0;
      entry_sum   <= '0;
      entry_min   <= '0;
      entry_max   <= '0;
    end
  end

endmodule

// File: design/hgba_checker.sv
// Port-level checks of the hash group-by aggregator.
// Watches the top level's ports only; attached by the bind at the end.
// Depends on hgba_pkg and hash_group_by_aggregator.
module hgba_checker import hgba_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        status,
  input logic [SLOT_W-1:0] slot,
  input logic              entry_used,
  input logic [31:0]       entry_count,
  input logic [63:0]       entry_sum
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds its transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot)
      && $stable(entry_sum))
    else $error("stalled result changed");

  // A hit or a new entry always reports a used slot.
  a_update_used: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_HIT || status == ST_NEW) |-> entry_used)
    else $error("updated slot reported unused");

  // A new group starts with exactly one element.
  a_new_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NEW |-> entry_count == 32'd1)
    else $error("new group count is not one");

  // Dropped and clear results carry no entry.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_CLEARED)
      |-> !entry_used && slot == '0 && entry_sum == 64'd0)
    else $error("dropped or clear result carries data");

endmodule

bind hash_group_by_aggregator hgba_checker u_hgba_checker (.*);
